// ===== rtl/pcanon_pkg.sv =====
// Shared constants and types for the path canonicalizer.
// Holds buffer and stack sizes, derived widths, action and result codes.
// No dependencies.
package pcanon_pkg;

    localparam int MAX_PATH_LEN = 256;
    localparam int MAX_DEPTH    = 128;

    localparam int BUF_AW    = $clog2(MAX_PATH_LEN);
    localparam int LEN_W     = $clog2(MAX_PATH_LEN + 1);
    localparam int STK_AW    = $clog2(MAX_DEPTH);
    localparam int CNT_W     = $clog2(MAX_DEPTH + 1);
    localparam int ACTION_W  = 2;
    localparam int BYTE_W    = 8;
    localparam int RES_LEN_W = 9;

    typedef logic [ACTION_W-1:0] t_action;
    typedef logic [BYTE_W-1:0]   t_byte;

    localparam t_action ACT_BYTE  = 2'd0;
    localparam t_action ACT_END   = 2'd1;
    localparam t_action ACT_DRAIN = 2'd2;

    localparam t_byte CHAR_SLASH = 8'h2F;
    localparam t_byte CHAR_DOT   = 8'h2E;

    localparam logic KIND_SUMMARY = 1'b0;
    localparam logic KIND_BYTE    = 1'b1;

endpackage

// ===== rtl/pcanon_ram.sv =====
// Generic single-write, single-read synchronous RAM.
// Read data is registered and holds when no read is issued.
// No dependencies.
module pcanon_ram #(
    parameter int DATA_W = 8,
    parameter int ADDR_W = 8,
    parameter int DEPTH  = 256
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/path_canonicalizer_top.sv =====
// Path canonicalizer top level: control sequencer, output register, buffer and stack RAMs.
// Depends on pcanon_pkg (sizes, codes) and pcanon_ram (buffer and start stack storage).
//
// Streams a Unix path in one byte per word (action 0), closes it with an end word
// (action 1) that returns a summary word with the canonical length and an overflow
// flag, then returns the canonical bytes one per drain word (action 2), the final
// byte marked last; after that byte the block is clear for the next path. The
// canonical bytes live in a 256 x 8 buffer RAM and the start offsets of kept
// components in a 128-entry stack RAM, both with a registered read port. One word
// is taken at a time: the first byte of a component also passes through S_WR2,
// since the buffer's single write port must store the separating slash and then
// the byte; a slash that closes a ".." component with a non-empty stack passes
// through S_POP for the stack read; an end word goes through S_FIN (after S_POP_END
// on such a pop) to S_SUM, and a drain word through S_DRD to S_DOUT, as RAM reads
// are registered. Result words sit in an output register, so path bytes are still
// taken while a result waits downstream. Bytes that do not fit in the buffer, and
// components beyond the stack depth, are dropped and flagged in the summary.
module path_canonicalizer_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  pcanon_pkg::t_action            i_action,
    input  pcanon_pkg::t_byte              i_path_byte,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic                           o_kind,
    output pcanon_pkg::t_byte              o_out_byte,
    output logic                           o_is_last,
    output logic [pcanon_pkg::RES_LEN_W-1:0] o_result_length,
    output logic                           o_overflowed
);

    localparam int LEN_W  = pcanon_pkg::LEN_W;
    localparam int BUF_AW = pcanon_pkg::BUF_AW;
    localparam int STK_AW = pcanon_pkg::STK_AW;
    localparam int CNT_W  = pcanon_pkg::CNT_W;

    // sequencer states
    localparam logic [2:0] S_IDLE    = 3'd0;  // take a word
    localparam logic [2:0] S_WR2     = 3'd1;  // store first byte after the slash
    localparam logic [2:0] S_POP     = 3'd2;  // stack read back, ".." on a slash
    localparam logic [2:0] S_POP_END = 3'd3;  // stack read back, ".." at end of path
    localparam logic [2:0] S_FIN     = 3'd4;  // empty path becomes "/", start draining
    localparam logic [2:0] S_SUM     = 3'd5;  // hand summary to output register
    localparam logic [2:0] S_DRD     = 3'd6;  // buffer read in flight
    localparam logic [2:0] S_DOUT    = 3'd7;  // hand drained byte to output register

    logic [2:0]        r_state, n_state;
    logic [LEN_W-1:0]  r_out_len, n_out_len;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [BUF_AW-1:0] r_comp_start, n_comp_start;
    logic [1:0]        r_comp_len, n_comp_len;    // saturates at 3
    logic              r_all_dots, n_all_dots;
    logic              r_ovf, n_ovf;
    logic [LEN_W-1:0]  r_drain_pos, n_drain_pos;
    logic              r_draining, n_draining;
    pcanon_pkg::t_byte r_byte, n_byte;

    // output register
    logic                             r_out_valid;
    logic                             r_kind, n_kind;
    pcanon_pkg::t_byte                r_obyte, n_obyte;
    logic                             r_last, n_last;
    logic [pcanon_pkg::RES_LEN_W-1:0] r_res_len, n_res_len;
    logic                             r_res_ovf, n_res_ovf;
    logic                             ld_out;
    logic                             out_free;

    // memory ports
    logic              buf_we, buf_re;
    logic [BUF_AW-1:0] buf_waddr, buf_raddr;
    pcanon_pkg::t_byte buf_wdata, buf_rdata;
    logic              stk_we, stk_re;
    logic [STK_AW-1:0] stk_waddr, stk_raddr;
    logic [BUF_AW-1:0] stk_rdata;

    logic              do_close, close_end, do_clear;
    logic [LEN_W:0]    len_plus2;
    logic [LEN_W:0]    pos_plus1;
    logic [CNT_W-1:0]  cnt_m1;
    logic              is_last;

    assign o_in_ready = (r_state == S_IDLE);
    assign out_free   = !r_out_valid || i_out_ready;
    assign len_plus2  = {1'b0, r_out_len} + (LEN_W + 1)'(2);
    assign pos_plus1  = {1'b0, r_drain_pos} + (LEN_W + 1)'(1);
    assign cnt_m1     = r_cnt - CNT_W'(1);
    assign is_last    = (pos_plus1 == {1'b0, r_out_len});

    always_comb begin
        n_state      = r_state;
        n_out_len    = r_out_len;
        n_cnt        = r_cnt;
        n_comp_start = r_comp_start;
        n_comp_len   = r_comp_len;
        n_all_dots   = r_all_dots;
        n_ovf        = r_ovf;
        n_drain_pos  = r_drain_pos;
        n_draining   = r_draining;
        n_byte       = r_byte;
        buf_we       = 1'b0;
        buf_waddr    = r_out_len[BUF_AW-1:0];
        buf_wdata    = i_path_byte;
        buf_re       = 1'b0;
        buf_raddr    = r_drain_pos[BUF_AW-1:0];
        stk_we       = 1'b0;
        stk_waddr    = r_cnt[STK_AW-1:0];
        stk_re       = 1'b0;
        stk_raddr    = cnt_m1[STK_AW-1:0];
        ld_out       = 1'b0;
        n_kind       = pcanon_pkg::KIND_SUMMARY;
        n_obyte      = '0;
        n_last       = 1'b0;
        n_res_len    = '0;
        n_res_ovf    = 1'b0;
        do_close     = 1'b0;
        close_end    = 1'b0;
        do_clear     = 1'b0;

        unique case (r_state) inside
            S_IDLE: begin
                if (i_in_valid) begin
                    unique case (i_action)
                        pcanon_pkg::ACT_BYTE: begin
                            if (!r_draining) begin
                                if (i_path_byte == pcanon_pkg::CHAR_SLASH) begin
                                    do_close = 1'b1;
                                end else if (r_comp_len == 2'd0) begin
                                    // new component: slash now, byte next cycle
                                    if (len_plus2 <= (LEN_W + 1)'(pcanon_pkg::MAX_PATH_LEN)) begin
                                        buf_we       = 1'b1;
                                        buf_wdata    = pcanon_pkg::CHAR_SLASH;
                                        n_comp_start = r_out_len[BUF_AW-1:0];
                                        n_out_len    = len_plus2[LEN_W-1:0];
                                        n_comp_len   = 2'd1;
                                        n_all_dots   = (i_path_byte == pcanon_pkg::CHAR_DOT);
                                        n_byte       = i_path_byte;
                                        n_state      = S_WR2;
                                    end else begin
                                        n_ovf = 1'b1;
                                    end
                                end else if (r_out_len < LEN_W'(pcanon_pkg::MAX_PATH_LEN)) begin
                                    buf_we    = 1'b1;
                                    n_out_len = r_out_len + LEN_W'(1);
                                    if (r_comp_len != 2'd3) begin
                                        n_comp_len = r_comp_len + 2'd1;
                                    end
                                    if (i_path_byte != pcanon_pkg::CHAR_DOT) begin
                                        n_all_dots = 1'b0;
                                    end
                                end else begin
                                    n_ovf = 1'b1;
                                end
                            end
                        end
                        pcanon_pkg::ACT_END: begin
                            if (!r_draining) begin
                                do_close  = 1'b1;
                                close_end = 1'b1;
                                n_state   = S_FIN;
                            end
                        end
                        pcanon_pkg::ACT_DRAIN: begin
                            if (r_draining) begin
                                if (r_drain_pos >= r_out_len
                                    || r_drain_pos >= LEN_W'(pcanon_pkg::MAX_PATH_LEN)) begin
                                    do_clear = 1'b1;
                                end else begin
                                    buf_re  = 1'b1;
                                    n_state = S_DRD;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_WR2: begin
                buf_we    = 1'b1;
                buf_waddr = BUF_AW'(r_out_len - LEN_W'(1));
                buf_wdata = r_byte;
                n_state   = S_IDLE;
            end
            S_POP, S_POP_END: begin
                n_out_len = LEN_W'(stk_rdata);
                n_cnt     = cnt_m1;
                n_state   = (r_state == S_POP_END) ? S_FIN : S_IDLE;
            end
            S_FIN: begin
                if (r_out_len == '0) begin
                    buf_we    = 1'b1;
                    buf_waddr = '0;
                    buf_wdata = pcanon_pkg::CHAR_SLASH;
                    n_out_len = LEN_W'(1);
                end
                n_draining  = 1'b1;
                n_drain_pos = '0;
                n_state     = S_SUM;
            end
            S_SUM: begin
                if (out_free) begin
                    ld_out    = 1'b1;
                    n_kind    = pcanon_pkg::KIND_SUMMARY;
                    n_res_len = pcanon_pkg::RES_LEN_W'(r_out_len);
                    n_res_ovf = r_ovf;
                    n_state   = S_IDLE;
                end
            end
            S_DRD: begin
                n_state = S_DOUT;
            end
            S_DOUT: begin
                if (out_free) begin
                    ld_out      = 1'b1;
                    n_kind      = pcanon_pkg::KIND_BYTE;
                    n_obyte     = buf_rdata;
                    n_last      = is_last;
                    n_drain_pos = pos_plus1[LEN_W-1:0];
                    do_clear    = is_last;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        // close component: drop "." (and ".." at root), pop on "..", push the rest if room
        if (do_close && r_comp_len != 2'd0) begin
            if (r_all_dots && r_comp_len == 2'd1) begin
                n_out_len = LEN_W'(r_comp_start);
            end else if (r_all_dots && r_comp_len == 2'd2) begin
                if (r_cnt != '0) begin
                    stk_re  = 1'b1;
                    n_state = close_end ? S_POP_END : S_POP;
                end else begin
                    n_out_len = LEN_W'(r_comp_start);
                end
            end else if (r_cnt < CNT_W'(pcanon_pkg::MAX_DEPTH)) begin
                stk_we = 1'b1;
                n_cnt  = r_cnt + CNT_W'(1);
            end else begin
                n_out_len = LEN_W'(r_comp_start);
                n_ovf     = 1'b1;
            end
            n_comp_len = 2'd0;
            n_all_dots = 1'b1;
        end

        // path done: back to the empty state
        if (do_clear) begin
            n_out_len    = '0;
            n_cnt        = '0;
            n_comp_start = '0;
            n_comp_len   = 2'd0;
            n_all_dots   = 1'b1;
            n_ovf        = 1'b0;
            n_drain_pos  = '0;
            n_draining   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_len    <= '0;
            r_cnt        <= '0;
            r_comp_start <= '0;
            r_comp_len   <= 2'd0;
            r_all_dots   <= 1'b1;
            r_ovf        <= 1'b0;
            r_drain_pos  <= '0;
            r_draining   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_out_len    <= n_out_len;
            r_cnt        <= n_cnt;
            r_comp_start <= n_comp_start;
            r_comp_len   <= n_comp_len;
            r_all_dots   <= n_all_dots;
            r_ovf        <= n_ovf;
            r_drain_pos  <= n_drain_pos;
            r_draining   <= n_draining;
            if (ld_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload: no reset needed
    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
        if (ld_out) begin
            r_kind    <= n_kind;
            r_obyte   <= n_obyte;
            r_last    <= n_last;
            r_res_len <= n_res_len;
            r_res_ovf <= n_res_ovf;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_kind          = r_kind;
    assign o_out_byte      = r_obyte;
    assign o_is_last       = r_last;
    assign o_result_length = r_res_len;
    assign o_overflowed    = r_res_ovf;

    pcanon_ram #(
        .DATA_W (pcanon_pkg::BYTE_W),
        .ADDR_W (BUF_AW),
        .DEPTH  (pcanon_pkg::MAX_PATH_LEN)
    ) u_buf_ram (
        .i_clk   (i_clk),
        .i_we    (buf_we),
        .i_waddr (buf_waddr),
        .i_wdata (buf_wdata),
        .i_re    (buf_re),
        .i_raddr (buf_raddr),
        .o_rdata (buf_rdata)
    );

    pcanon_ram #(
        .DATA_W (BUF_AW),
        .ADDR_W (STK_AW),
        .DEPTH  (pcanon_pkg::MAX_DEPTH)
    ) u_stk_ram (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_waddr),
        .i_wdata (r_comp_start),
        .i_re    (stk_re),
        .i_raddr (stk_raddr),
        .o_rdata (stk_rdata)
    );

`ifndef SYNTHESIS
    a_stack_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(pcanon_pkg::MAX_DEPTH))
        else $error("stack count beyond depth");

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_len <= LEN_W'(pcanon_pkg::MAX_PATH_LEN))
        else $error("buffer length beyond capacity");

    a_drain_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_draining |-> (r_drain_pos < r_out_len))
        else $error("drain position past end of path");

    a_wr2_comp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WR2) |-> (r_comp_len == 2'd1 && r_out_len >= LEN_W'(2)))
        else $error("second component write without an open component");

    a_sum_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_kind == pcanon_pkg::KIND_SUMMARY) |-> (r_res_len != '0))
        else $error("summary reports an empty path");
`endif

endmodule
